@@ sv/assert_macros.svh @@
// assertion macros shared by the congestion window control block
// no dependencies; the including module provides clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CWC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwc check failed");

// delayed implication
`define CWC_ASSERT_AFTER2(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("cwc check failed");

`endif

@@ sv/cwc_pkg.sv @@
// types, codes and helpers for the congestion window control block
// no dependencies; imported by every module of the block
package cwc_pkg;

    localparam int unsigned WIDE_BITS = 32;
    localparam int unsigned ACK_BITS  = 20;
    localparam int unsigned THR_BITS  = 13;
    localparam int unsigned WIN_OUT_BITS = 13;
    localparam int unsigned SEQ_OUT_BITS = 20;
    localparam int unsigned CNT_OUT_BITS = 13;
    localparam int unsigned CFG_DATA_BITS = 20;

    localparam logic [THR_BITS-1:0] THR_CAP   = 13'd4096;
    localparam logic [THR_BITS-1:0] FR_EXTRA  = 13'd3;
    localparam logic [1:0]          DUP_FAST_LEVEL = 2'd2;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_TIMEOUT = 2'd2,
        ACT_TICK    = 2'd3
    } cwc_action_t;

    typedef enum logic [2:0] {
        KIND_START   = 3'd0,
        KIND_ACK     = 3'd1,
        KIND_DUP     = 3'd2,
        KIND_FAST    = 3'd3,
        KIND_TIMEOUT = 3'd4,
        KIND_TICK    = 3'd5
    } cwc_kind_t;

    typedef enum logic [1:0] {
        CFG_SMALL_FILE     = 2'd0,
        CFG_INIT_THRESHOLD = 2'd1,
        CFG_TOTAL_SEGMENTS = 2'd2
    } cwc_cfg_index_t;

    typedef struct packed {
        logic [1:0]          action;
        logic [ACK_BITS-1:0] ack_number;
    } cwc_in_t;

    typedef struct packed {
        logic [2:0]              event_kind;
        logic [WIN_OUT_BITS-1:0] window_size;
        logic [THR_BITS-1:0]     slow_start_threshold;
        logic [SEQ_OUT_BITS-1:0] send_first;
        logic [CNT_OUT_BITS-1:0] send_count;
        logic                    transfer_done;
    } cwc_out_t;

    typedef struct packed {
        cwc_kind_t           kind;
        logic [ACK_BITS-1:0] ack_number;
    } cwc_cmd_t;

    typedef struct packed {
        logic                small_file_mode;
        logic [THR_BITS-1:0] initial_threshold;
        logic [ACK_BITS-1:0] total_segments;
    } cwc_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cwc_queue_status_t;

    function automatic logic [THR_BITS-1:0] sat_thr(input logic [WIDE_BITS-1:0] v);
        return (v > WIDE_BITS'(THR_CAP)) ? THR_CAP : v[THR_BITS-1:0];
    endfunction

endpackage

@@ sv/cwc_front.sv @@
// front end: accepts events, tracks repeated acks and classifies each event
// depends on cwc_pkg
module cwc_front
    import cwc_pkg::*;
#(
    parameter int SEQ_BITS = 20
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cwc_in_t           in_data,
    input  cwc_queue_status_t q_status,
    output logic              push,
    output cwc_cmd_t          push_data
);

    logic [SEQ_BITS-1:0]  prev_ack_reg;
    logic [SEQ_BITS-1:0]  prev_ack_next;
    logic [1:0]           dup_count_reg;
    logic [1:0]           dup_count_next;
    logic [WIDE_BITS-1:0] ack_wide;
    logic [SEQ_BITS-1:0]  ack_seq;
    cwc_kind_t            kind;

    assign ack_wide = WIDE_BITS'(in_data.ack_number);
    assign ack_seq  = ack_wide[SEQ_BITS-1:0];
    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    always_comb
    begin
        prev_ack_next  = prev_ack_reg;
        dup_count_next = dup_count_reg;
        kind           = KIND_START;
        unique case (cwc_action_t'(in_data.action))
            ACT_START:
            begin
                kind           = KIND_START;
                prev_ack_next  = '0;
                dup_count_next = '0;
            end
            ACT_ACK:
            begin
                if (ack_seq == prev_ack_reg)
                begin
                    if (dup_count_reg == DUP_FAST_LEVEL)
                    begin
                        dup_count_next = '0;
                        kind           = KIND_FAST;
                    end
                    else
                    begin
                        dup_count_next = dup_count_reg + 2'd1;
                        kind           = KIND_DUP;
                    end
                end
                else
                begin
                    dup_count_next = '0;
                    prev_ack_next  = ack_seq;
                    kind           = KIND_ACK;
                end
            end
            ACT_TIMEOUT:
            begin
                kind = KIND_TIMEOUT;
            end
            ACT_TICK:
            begin
                kind = KIND_TICK;
            end
            default:
            begin
                kind = KIND_TICK;
            end
        endcase
    end

    assign push_data.kind       = kind;
    assign push_data.ack_number = in_data.ack_number;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ack_reg  <= '0;
            dup_count_reg <= '0;
        end
        else if (push)
        begin
            prev_ack_reg  <= prev_ack_next;
            dup_count_reg <= dup_count_next;
        end
    end

endmodule

@@ sv/cwc_queue.sv @@
// two-entry command queue between the front end and the window engine
// depends on cwc_pkg
module cwc_queue
    import cwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cwc_cmd_t          push_data,
    input  logic              pop,
    output cwc_cmd_t          pop_data,
    output cwc_queue_status_t status
);

    localparam int DEPTH = 2;

    cwc_cmd_t   entry_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign status.full  = (count_reg == 2'(DEPTH));
    assign status.empty = (count_reg == 2'd0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/cwc_back.sv @@
// window engine: applies one classified event per cycle unless the output stalls;
// holds the result register; depends on cwc_pkg
module cwc_back
    import cwc_pkg::*;
#(
    parameter int MAX_WINDOW = 4096,
    parameter int SEQ_BITS   = 20
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cwc_cfg_t          cfg,
    input  cwc_queue_status_t q_status,
    input  cwc_cmd_t          cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output cwc_out_t          out_data
);

    localparam int WIN_BITS = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS = ((SEQ_BITS > WIN_BITS) ? SEQ_BITS : WIN_BITS) + 1;
    localparam int CMP_BITS = (WIN_BITS > int'(THR_BITS)) ? WIN_BITS : int'(THR_BITS);
    localparam logic [WIN_BITS-1:0] WIN_MAX = WIN_BITS'(MAX_WINDOW);
    localparam logic [WIN_BITS-1:0] WIN_ONE = WIN_BITS'(1);
    localparam logic [WIN_BITS-1:0] WIN_TWO = WIN_BITS'(2);

    logic [WIN_BITS-1:0] window_reg, window_next;
    logic [THR_BITS-1:0] threshold_reg, threshold_next;
    logic [SEQ_BITS-1:0] high_ack_reg, high_ack_next;
    logic [SEQ_BITS-1:0] high_sent_reg, high_sent_next;
    logic                avoid_reg, avoid_next;
    logic                ticker_reg, ticker_next;
    logic                out_valid_reg, out_valid_next;
    cwc_out_t            out_data_reg, out_data_next;

    logic [WIDE_BITS-1:0] ack_wide, total_wide;
    logic [SEQ_BITS-1:0]  ack_seq, total_m;
    logic                 win_ge_thr;

    // ack path
    logic                grow;
    logic                ack_above;
    logic [SEQ_BITS-1:0] incr;
    logic [SUM_BITS-1:0] win_sum;
    logic [WIN_BITS-1:0] win_grown;
    logic [WIN_BITS-1:0] ack_win;
    logic [SEQ_BITS-1:0] ack_ha;

    // tick, fast retransmit, timeout, start
    logic [WIN_BITS:0]    tick_sum;
    logic [WIN_BITS-1:0]  tick_win;
    logic [THR_BITS-1:0]  fast_thr;
    logic [THR_BITS:0]    fast_sum;
    logic [WIDE_BITS-1:0] fast_wide;
    logic [WIN_BITS-1:0]  fast_win;
    logic [SEQ_BITS-1:0]  outstanding;
    logic [THR_BITS-1:0]  to_thr;
    logic [THR_BITS-1:0]  start_thr;

    // resend of the first unacked segment
    logic                resend_ok;
    logic [SEQ_BITS-1:0] resend_first;
    logic [SEQ_BITS-1:0] resend_hs;

    // window opening
    logic                is_start;
    logic [SEQ_BITS-1:0] ow_ha, ow_hs, ow_base;
    logic [WIN_BITS-1:0] ow_win;
    logic [SUM_BITS-1:0] ow_top, ow_top_c, ow_count;
    logic                ow_open;
    logic [SEQ_BITS-1:0] ow_first, ow_hs_new;

    logic [SEQ_BITS-1:0]  res_first;
    logic [SUM_BITS-1:0]  res_count;
    logic [WIDE_BITS-1:0] win_out_wide, first_wide, count_wide;

    assign ack_wide   = WIDE_BITS'(cmd.ack_number);
    assign ack_seq    = ack_wide[SEQ_BITS-1:0];
    assign total_wide = WIDE_BITS'(cfg.total_segments);
    assign total_m    = total_wide[SEQ_BITS-1:0];
    assign win_ge_thr = CMP_BITS'(window_reg) >= CMP_BITS'(threshold_reg);

    assign grow      = win_ge_thr || avoid_reg;
    assign ack_above = ack_seq > high_ack_reg;
    assign incr      = (high_ack_reg == '0) ? SEQ_BITS'(1)
                     : (ack_above ? (ack_seq - high_ack_reg) : '0);
    assign win_sum   = SUM_BITS'(window_reg) + SUM_BITS'(incr);
    assign win_grown = (win_sum > SUM_BITS'(MAX_WINDOW)) ? WIN_MAX : win_sum[WIN_BITS-1:0];
    assign ack_win   = grow ? ((window_reg == WIN_ONE) ? WIN_TWO : window_reg) : win_grown;
    assign ack_ha    = ack_above ? ack_seq : high_ack_reg;

    assign tick_sum  = (WIN_BITS + 1)'(window_reg) + (WIN_BITS + 1)'(1);
    assign tick_win  = (tick_sum > (WIN_BITS + 1)'(MAX_WINDOW)) ? WIN_MAX
                     : tick_sum[WIN_BITS-1:0];

    assign fast_thr  = sat_thr(WIDE_BITS'(window_reg >> 1));
    assign fast_sum  = (THR_BITS + 1)'(fast_thr) + (THR_BITS + 1)'(FR_EXTRA);
    assign fast_wide = WIDE_BITS'(fast_sum);
    assign fast_win  = (fast_wide > WIDE_BITS'(MAX_WINDOW)) ? WIN_MAX
                     : fast_wide[WIN_BITS-1:0];

    assign outstanding = (high_sent_reg > high_ack_reg) ? (high_sent_reg - high_ack_reg) : '0;
    assign to_thr      = sat_thr(WIDE_BITS'(outstanding >> 1));
    assign start_thr   = sat_thr(WIDE_BITS'(cfg.initial_threshold));

    assign resend_ok    = high_ack_reg < total_m;
    assign resend_first = high_ack_reg + SEQ_BITS'(1);
    assign resend_hs    = resend_ok ? resend_first : high_ack_reg;

    assign is_start  = (cmd.kind == KIND_START);
    assign ow_ha     = is_start ? '0 : ack_ha;
    assign ow_hs     = is_start ? '0 : high_sent_reg;
    assign ow_win    = is_start ? WIN_ONE : ack_win;
    assign ow_base   = (ow_hs > ow_ha) ? ow_hs : ow_ha;
    assign ow_top    = SUM_BITS'(ow_ha) + SUM_BITS'(ow_win);
    assign ow_top_c  = (ow_top > SUM_BITS'(total_m)) ? SUM_BITS'(total_m) : ow_top;
    assign ow_open   = ow_top_c > SUM_BITS'(ow_base);
    assign ow_count  = ow_open ? (ow_top_c - SUM_BITS'(ow_base)) : '0;
    assign ow_first  = ow_open ? (ow_base + SEQ_BITS'(1)) : '0;
    assign ow_hs_new = ow_open ? ow_top_c[SEQ_BITS-1:0] : ow_hs;

    assign pop = !q_status.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        window_next    = window_reg;
        threshold_next = threshold_reg;
        high_ack_next  = high_ack_reg;
        high_sent_next = high_sent_reg;
        avoid_next     = avoid_reg;
        ticker_next    = ticker_reg;
        res_first      = '0;
        res_count      = '0;
        unique case (cmd.kind)
            KIND_START:
            begin
                window_next    = WIN_ONE;
                threshold_next = start_thr;
                high_ack_next  = '0;
                high_sent_next = ow_hs_new;
                avoid_next     = 1'b0;
                ticker_next    = 1'b0;
                res_first      = ow_first;
                res_count      = ow_count;
            end
            KIND_ACK, KIND_DUP:
            begin
                window_next    = ack_win;
                high_ack_next  = ack_ha;
                high_sent_next = ow_hs_new;
                ticker_next    = ticker_reg || grow;
                res_first      = ow_first;
                res_count      = ow_count;
            end
            KIND_FAST:
            begin
                if (!cfg.small_file_mode)
                begin
                    threshold_next = fast_thr;
                    window_next    = fast_win;
                    avoid_next     = 1'b1;
                end
                high_sent_next = resend_hs;
                res_first      = resend_ok ? resend_first : '0;
                res_count      = SUM_BITS'(resend_ok);
            end
            KIND_TIMEOUT:
            begin
                if (!cfg.small_file_mode)
                begin
                    window_next    = WIN_ONE;
                    threshold_next = to_thr;
                end
                high_sent_next = resend_hs;
                res_first      = resend_ok ? resend_first : '0;
                res_count      = SUM_BITS'(resend_ok);
            end
            KIND_TICK:
            begin
                if (ticker_reg && win_ge_thr)
                begin
                    window_next = tick_win;
                end
            end
            default:
            begin
                window_next = window_reg;
            end
        endcase
    end

    assign win_out_wide = WIDE_BITS'(window_next);
    assign first_wide   = WIDE_BITS'(res_first);
    assign count_wide   = WIDE_BITS'(res_count);

    always_comb
    begin
        out_data_next.event_kind           = cmd.kind;
        out_data_next.window_size          = win_out_wide[WIN_OUT_BITS-1:0];
        out_data_next.slow_start_threshold = threshold_next;
        out_data_next.send_first           = first_wide[SEQ_OUT_BITS-1:0];
        out_data_next.send_count           = count_wide[CNT_OUT_BITS-1:0];
        out_data_next.transfer_done        = high_ack_next >= total_m;
        out_valid_next = pop ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WIN_ONE;
            threshold_reg <= THR_CAP;
            high_ack_reg  <= '0;
            high_sent_reg <= '0;
            avoid_reg     <= 1'b0;
            ticker_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                window_reg    <= window_next;
                threshold_reg <= threshold_next;
                high_ack_reg  <= high_ack_next;
                high_sent_reg <= high_sent_next;
                avoid_reg     <= avoid_next;
                ticker_reg    <= ticker_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ sv/congestion_window_control_top.sv @@
// top level of the congestion window control block: config registers and assertions
// depends on cwc_pkg, cwc_front, cwc_queue, cwc_back and assert_macros.svh
//
// usage
// - input channel in_valid/in_stall/in_data carries one event per transfer:
//   start, ack received, receive timeout or avoidance tick
// - output channel out_valid/out_stall/out_data returns one result per event:
//   event kind, window, threshold, segment range to send and a done flag
// - cfg_write_en/cfg_index/cfg_data write small_file_mode, initial_threshold
//   and total_segments; write them only while no event is in flight
// - an input transfer is registered in the queue and then in the output register
//   before its result is valid; one event per cycle is sustained while the output
//   is not stalled, set by the combinational window update in the engine
// - the front end classifies repeated acks, a two-entry queue decouples it
//   from the window engine, and the engine feeds an output register
// - a stalled output holds its result; the queue absorbs two more events
//   before in_stall rises
// - reset loads window 1, threshold 4096, total_segments 1 and clears all
//   ack and send tracking; no clearing pass is needed
`include "assert_macros.svh"

module congestion_window_control_top
    import cwc_pkg::*;
#(
    parameter int MAX_WINDOW = 4096,
    parameter int SEQ_BITS   = 20
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  cwc_in_t                  in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output cwc_out_t                 out_data,
    input  logic                     cfg_write_en,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cwc_cfg_t          cfg_reg;
    cwc_cfg_t          cfg_next;
    cwc_queue_status_t q_status;
    logic              push;
    cwc_cmd_t          push_data;
    logic              pop;
    cwc_cmd_t          pop_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cwc_cfg_index_t'(cfg_index))
                CFG_SMALL_FILE:     cfg_next.small_file_mode   = cfg_data[0];
                CFG_INIT_THRESHOLD: cfg_next.initial_threshold = cfg_data[THR_BITS-1:0];
                CFG_TOTAL_SEGMENTS: cfg_next.total_segments    = cfg_data[ACK_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.small_file_mode   <= 1'b0;
            cfg_reg.initial_threshold <= THR_CAP;
            cfg_reg.total_segments    <= ACK_BITS'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cwc_front #(
        .SEQ_BITS (SEQ_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    cwc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    cwc_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .SEQ_BITS   (SEQ_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .cmd       (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `CWC_ASSERT_SAME(a_no_send_no_first, out_valid && (out_data.send_count == '0), out_data.send_first == '0)
    `CWC_ASSERT_SAME(a_tick_never_sends, out_valid && (out_data.event_kind == KIND_TICK), out_data.send_count == '0)
    `CWC_ASSERT_SAME(a_timeout_collapses, out_valid && (out_data.event_kind == KIND_TIMEOUT) && !cfg_reg.small_file_mode, out_data.window_size == WIN_OUT_BITS'(1))
    `CWC_ASSERT_AFTER2(a_start_latency, in_valid && !in_stall && (in_data.action == ACT_START) && q_status.empty && (!out_valid || !out_stall), out_valid && (out_data.event_kind == KIND_START) && (out_data.window_size == WIN_OUT_BITS'(1)))

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for congestion_window_control_top
// depends on cwc_pkg and the block's rtl; a queue-fed driver and a clocked monitor
// check every result transfer against a window predictor kept in the testbench
module testbench;
    import cwc_pkg::*;

    localparam int unsigned WIN_MAX     = 4096;
    localparam int unsigned THR_LIMIT   = 4096;
    localparam int unsigned FR_BOOST    = 3;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          MAX_REPORTS = 10;
    localparam int          PHASE_ITEMS = 250;
    localparam int          PHASES      = 7;

    typedef struct packed {
        logic [12:0] window;
        logic [12:0] threshold;
        logic [19:0] hi_ack;
        logic [19:0] hi_sent;
        logic [19:0] last_ack;
        logic [1:0]  dups;
        logic        avoid;
        logic        ticking;
    } session_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    cwc_in_t                  in_data = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    cwc_out_t                 out_data;
    logic                     cfg_write_en = 1'b0;
    logic [1:0]               cfg_index = 2'd0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    cwc_in_t  event_queue[$];
    cwc_out_t due_results[$];
    cwc_cfg_t cfg_now;
    session_t track_session;
    session_t plan_session;
    cwc_out_t want;
    logic     took_in = 1'b0;
    logic     idle_enable = 1'b1;
    int       in_gap = 0;
    int       out_gap = 0;
    int       quiet = 0;
    int       fails = 0;

    congestion_window_control_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic session_t fresh_session(input logic [12:0] thr);
        session_t s;
        s = '0;
        s.window = 13'd1;
        s.threshold = (thr > THR_LIMIT) ? 13'(THR_LIMIT) : thr;
        return s;
    endfunction

    function automatic cwc_out_t step_window(inout session_t s, input cwc_cfg_t c,
                                             input cwc_in_t item);
        int unsigned ack, total, win, thr, ha, hs, base, top, first, count, outst;
        bit          fast;
        cwc_kind_t   kind;
        cwc_out_t    r;
        ack = item.ack_number;
        total = c.total_segments;
        win = s.window;
        thr = s.threshold;
        ha = s.hi_ack;
        hs = s.hi_sent;
        first = 0;
        count = 0;
        fast = 1'b0;
        kind = KIND_TICK;
        case (cwc_action_t'(item.action))
            ACT_START:
            begin
                s = fresh_session(c.initial_threshold);
                win = 1;
                thr = s.threshold;
                ha = 0;
                hs = 0;
                kind = KIND_START;
            end
            ACT_ACK:
            begin
                if (ack == s.last_ack)
                begin
                    if (s.dups == 2'd2)
                    begin
                        s.dups = 2'd0;
                        fast = 1'b1;
                    end
                    else
                        s.dups = s.dups + 2'd1;
                end
                else
                    s.dups = 2'd0;
                if (fast)
                begin
                    kind = KIND_FAST;
                    if (!c.small_file_mode)
                    begin
                        thr = win / 2;
                        if (thr > THR_LIMIT)
                            thr = THR_LIMIT;
                        win = thr + FR_BOOST;
                        if (win > WIN_MAX)
                            win = WIN_MAX;
                        s.avoid = 1'b1;
                    end
                end
                else
                begin
                    kind = (ack == s.last_ack) ? KIND_DUP : KIND_ACK;
                    s.last_ack = ack;
                    if (win >= thr || s.avoid)
                    begin
                        s.ticking = 1'b1;
                        if (win == 1)
                            win = 2;
                    end
                    else if (ha == 0)
                        win = win + 1;
                    else if (ack > ha)
                        win = win + (ack - ha);
                    if (win > WIN_MAX)
                        win = WIN_MAX;
                    if (ack > ha)
                        ha = ack;
                end
            end
            ACT_TIMEOUT:
            begin
                kind = KIND_TIMEOUT;
                if (!c.small_file_mode)
                begin
                    outst = (hs > ha) ? hs - ha : 0;
                    win = 1;
                    thr = outst / 2;
                    if (thr > THR_LIMIT)
                        thr = THR_LIMIT;
                end
            end
            default:
            begin
                kind = KIND_TICK;
                if (s.ticking && win >= thr)
                begin
                    win = win + 1;
                    if (win > WIN_MAX)
                        win = WIN_MAX;
                end
            end
        endcase
        // segments opened by the window, or the single resend
        if (kind == KIND_START || kind == KIND_ACK || kind == KIND_DUP)
        begin
            base = (hs > ha) ? hs : ha;
            top = ha + win;
            if (top > total)
                top = total;
            if (top > base)
            begin
                first = base + 1;
                count = top - base;
                hs = top;
            end
        end
        else if (kind == KIND_FAST || kind == KIND_TIMEOUT)
        begin
            if (ha < total)
            begin
                first = ha + 1;
                count = 1;
                hs = ha + 1;
            end
            else
                hs = ha;
        end
        s.window = 13'(win);
        s.threshold = 13'(thr);
        s.hi_ack = 20'(ha);
        s.hi_sent = 20'(hs);
        r.event_kind = kind;
        r.window_size = 13'(win);
        r.slow_start_threshold = 13'(thr);
        r.send_first = 20'(first);
        r.send_count = 13'(count);
        r.transfer_done = (ha >= total);
        return r;
    endfunction

    task automatic push_item(input cwc_action_t act, input logic [19:0] ack);
        cwc_in_t item;
        item.action = act;
        item.ack_number = ack;
        event_queue.push_back(item);
        void'(step_window(plan_session, cfg_now, item));
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (event_queue.size() != 0 || in_valid || due_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cwc_cfg_index_t idx, input logic [19:0] v);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            CFG_SMALL_FILE:     cfg_now.small_file_mode = v[0];
            CFG_INIT_THRESHOLD: cfg_now.initial_threshold = v[12:0];
            default:            cfg_now.total_segments = v;
        endcase
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic apply_settings(input logic sf_mode, input logic [12:0] thr,
                                  input logic [19:0] total);
        wait_idle();
        write_reg(CFG_SMALL_FILE, 20'(sf_mode));
        write_reg(CFG_INIT_THRESHOLD, 20'(thr));
        write_reg(CFG_TOTAL_SEGMENTS, total);
        plan_session = track_session;
    endtask

    task automatic gen_phase(input int n_items);
        int          made;
        int          pick;
        int          reps;
        int unsigned span;
        made = 0;
        plan_session = track_session;
        push_item(ACT_START, 20'($urandom));
        made++;
        while (made < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                push_item(cwc_action_t'($urandom_range(0, 3)), 20'($urandom));
            else if (pick < 11)
                push_item(ACT_START, 20'($urandom));
            else if (pick < 58)
            begin
                span = (plan_session.hi_sent > plan_session.hi_ack) ?
                       plan_session.hi_sent - plan_session.hi_ack : 0;
                push_item(ACT_ACK, 20'(plan_session.hi_ack + $urandom_range(0, span)));
            end
            else if (pick < 68)
            begin
                reps = $urandom_range(1, 4);
                repeat (reps) push_item(ACT_ACK, plan_session.last_ack);
                made += reps - 1;
            end
            else if (pick < 73)
                push_item(ACT_ACK, 20'($urandom_range(0, plan_session.hi_ack)));
            else if (pick < 80)
                push_item(ACT_TIMEOUT, 20'($urandom));
            else
                push_item(ACT_TICK, 20'($urandom));
            made++;
        end
    endtask

    // input side: hold a stalled transfer, otherwise idle in bursts or send the next event
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || took_in))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (idle_enable && event_queue.size() != 0 && $urandom_range(0, 15) == 0)
            begin
                in_gap <= $urandom_range(0, 17);
                in_valid <= 1'b0;
            end
            else if (event_queue.size() != 0)
            begin
                in_data <= event_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_gap <= out_gap - 1;
            out_stall <= 1'b1;
        end
        else if (idle_enable && $urandom_range(0, 15) == 0)
        begin
            out_gap <= $urandom_range(0, 17);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took_in <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                due_results.push_back(step_window(track_session, cfg_now, in_data));
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("unexpected result transfer: %p", out_data);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (out_data.event_kind !== want.event_kind
                        || out_data.window_size !== want.window_size
                        || out_data.slow_start_threshold !== want.slow_start_threshold
                        || out_data.send_first !== want.send_first
                        || out_data.send_count !== want.send_count
                        || out_data.transfer_done !== want.transfer_done)
                    begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("mismatch kind %0d/%0d win %0d/%0d thr %0d/%0d first %0d/%0d cnt %0d/%0d done %0d/%0d (exp/got)",
                                     want.event_kind, out_data.event_kind,
                                     want.window_size, out_data.window_size,
                                     want.slow_start_threshold, out_data.slow_start_threshold,
                                     want.send_first, out_data.send_first,
                                     want.send_count, out_data.send_count,
                                     want.transfer_done, out_data.transfer_done);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet <= 0;
            else if (quiet + 1 >= QUIET_LIMIT)
            begin
                $display("congestion_window_control_top regression: fail");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        int          phase;
        logic        sf_pick;
        logic [12:0] thr_pick;
        logic [19:0] total_pick;
        cfg_now = {1'b0, 13'd4096, 20'd1};
        track_session = fresh_session(13'd4096);
        plan_session = track_session;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: ack of zero repeats the initial ack
        push_item(ACT_START, 20'd0);
        push_item(ACT_ACK, 20'd0);
        push_item(ACT_TICK, 20'hFFFFF);
        push_item(ACT_TIMEOUT, 20'd0);

        // low threshold: duplicates into fast retransmit, ack far past the total
        apply_settings(1'b0, 13'd8, 20'd999999);
        push_item(ACT_START, 20'd0);
        push_item(ACT_ACK, 20'd1);
        push_item(ACT_ACK, 20'd3);
        push_item(ACT_ACK, 20'd3);
        push_item(ACT_ACK, 20'd3);
        push_item(ACT_ACK, 20'd3);
        push_item(ACT_TICK, 20'd0);
        push_item(ACT_TICK, 20'd0);
        push_item(ACT_ACK, 20'hFFFFF);
        push_item(ACT_TICK, 20'd0);
        push_item(ACT_TIMEOUT, 20'd0);

        // small-file mode with an oversized initial threshold
        apply_settings(1'b1, 13'd8191, 20'd20);
        push_item(ACT_START, 20'd0);
        push_item(ACT_ACK, 20'd2);
        push_item(ACT_ACK, 20'd2);
        push_item(ACT_ACK, 20'd2);
        push_item(ACT_ACK, 20'd2);
        push_item(ACT_TIMEOUT, 20'd0);
        push_item(ACT_ACK, 20'd20);
        push_item(ACT_TIMEOUT, 20'd0);

        apply_settings(1'b0, 13'd1, 20'd1);
        push_item(ACT_START, 20'd0);
        push_item(ACT_ACK, 20'd1);

        for (phase = 0; phase < PHASES; phase++)
        begin
            sf_pick = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       thr_pick = 13'd1;
                1:       thr_pick = 13'd4096;
                2:       thr_pick = 13'($urandom_range(2, 64));
                default: thr_pick = 13'($urandom_range(1, 4096));
            endcase
            case ($urandom_range(0, 3))
                0:       total_pick = 20'd1;
                1:       total_pick = 20'd999999;
                2:       total_pick = 20'($urandom_range(1, 60));
                default: total_pick = 20'($urandom_range(100, 20000));
            endcase
            apply_settings(sf_pick, thr_pick, total_pick);
            // last part runs at full rate on both sides
            if (phase == PHASES - 1)
                idle_enable = 1'b0;
            gen_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("congestion_window_control_top regression: pass");
        else
            $display("congestion_window_control_top regression: fail");
        $finish;
    end

endmodule
